// ===== rtl/core/psd_pkg.sv =====
// Shared constants and types for the point to segment distance block.
`default_nettype none
package psd_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } psd_q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/psd_if.sv =====
// Stream interfaces for the point to segment distance block.
`default_nettype none
interface psd_in_if #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;
  logic signed [COORD_WIDTH-1:0] seg_start_x;
  logic signed [COORD_WIDTH-1:0] seg_start_y;
  logic signed [COORD_WIDTH-1:0] seg_end_x;
  logic signed [COORD_WIDTH-1:0] seg_end_y;

  modport source (output valid, query_x, query_y, seg_start_x, seg_start_y,
                  seg_end_x, seg_end_y, input ready);
  modport sink (input valid, query_x, query_y, seg_start_x, seg_start_y,
                seg_end_x, seg_end_y, output ready);
endinterface

interface psd_out_if #(
  parameter int DIST_WIDTH = psd_pkg::COORD_WIDTH_DEF + psd_pkg::FRAC_BITS_DEF + 1
) ();
  logic                  valid;
  logic                  ready;
  logic [DIST_WIDTH-1:0] distance;
  logic                  foot_on_segment;

  modport source (output valid, distance, foot_on_segment, input ready);
  modport sink (input valid, distance, foot_on_segment, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/point_segment_distance.sv =====
// Point to segment distance: when the result side never stalls, one beat a cycle is
// accepted and delivered. Each beat passes the six-stage front pipeline, the queue, one
// divider stage per quotient bit and one square root stage per distance bit, then the
// output register.
// Reset clears all valid flags and queue pointers; payload registers keep their contents.
`default_nettype none
module point_segment_distance #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = psd_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  psd_in_if.sink    in_ch,
  psd_out_if.source out_ch
);

  localparam int LW         = 2 * COORD_WIDTH + 2;
  localparam int NW         = 4 * COORD_WIDTH + 4 + 2 * FRAC_BITS;
  localparam int QDW        = NW + LW + 1;
  localparam int DIST_WIDTH = COORD_WIDTH + FRAC_BITS + 1;

  psd_pkg::psd_q_stat_t q_stat;
  logic                 push, pop;
  logic [QDW-1:0]       push_data, pop_data;

  psd_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .QDW         (QDW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_query_x     (in_ch.query_x),
    .in_query_y     (in_ch.query_y),
    .in_seg_start_x (in_ch.seg_start_x),
    .in_seg_start_y (in_ch.seg_start_y),
    .in_seg_end_x   (in_ch.seg_end_x),
    .in_seg_end_y   (in_ch.seg_end_y),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  psd_queue #(
    .WIDTH (QDW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  psd_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .QDW         (QDW),
    .DIST_WIDTH  (DIST_WIDTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .pop_data            (pop_data),
    .pop                 (pop),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_distance        (out_ch.distance),
    .out_foot_on_segment (out_ch.foot_on_segment)
  );

endmodule
`default_nettype wire

// ===== rtl/core/psd_front.sv =====
// Front pipeline: differences, products, classification and dividend setup.
`default_nettype none
module psd_front #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = psd_pkg::FRAC_BITS_DEF,
  parameter int QDW         = 6 * COORD_WIDTH + 7 + 2 * FRAC_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_query_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_query_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_end_y,
  input  wire psd_pkg::psd_q_stat_t          q_stat,
  output logic                               push,
  output logic [QDW-1:0]                     push_data
);

  localparam int DFW = COORD_WIDTH + 1;
  localparam int PW  = 2 * COORD_WIDTH + 2;
  localparam int SW  = 2 * COORD_WIDTH + 3;
  localparam int LW  = 2 * COORD_WIDTH + 2;
  localparam int HW  = COORD_WIDTH + 1;
  localparam int NW  = 4 * COORD_WIDTH + 4 + 2 * FRAC_BITS;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic signed [DFW-1:0] dx_r, dy_r, ex_r, ey_r, fx_r, fy_r;
  logic signed [PW-1:0]  p_tx_r, p_ty_r, p_cx_r, p_cy_r;
  logic signed [PW-1:0]  l_x_r, l_y_r, a_x_r, a_y_r, b_x_r, b_y_r;
  logic signed [SW-1:0]  t_r, cr_r;
  logic [LW-1:0]         len_r, sqa_r, sqb_r;
  logic                  foot4_r, foot5_r, foot6_r;
  logic [LW-1:0]         crmag_r, sqmin4_r, sqmin5_r, den4_r, den5_r, den6_r;
  logic [2*HW-1:0]       hh_r, hl_r, ll_r;
  logic [NW-1:0]         num_r;
  logic [NW-1:0]         crsq;

  assign adv       = !(v6_r && q_stat.full);
  assign in_ready  = adv;
  assign push      = v6_r && !q_stat.full;
  assign push_data = {foot6_r, den6_r, num_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  assign crsq = (NW'(hh_r) << (2 * HW)) + (NW'(hl_r) << (HW + 1)) + NW'(ll_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r <= DFW'(in_seg_end_x) - DFW'(in_seg_start_x);
      dy_r <= DFW'(in_seg_end_y) - DFW'(in_seg_start_y);
      ex_r <= DFW'(in_query_x) - DFW'(in_seg_start_x);
      ey_r <= DFW'(in_query_y) - DFW'(in_seg_start_y);
      fx_r <= DFW'(in_query_x) - DFW'(in_seg_end_x);
      fy_r <= DFW'(in_query_y) - DFW'(in_seg_end_y);

      p_tx_r <= PW'(ex_r) * PW'(dx_r);
      p_ty_r <= PW'(ey_r) * PW'(dy_r);
      p_cx_r <= PW'(ex_r) * PW'(dy_r);
      p_cy_r <= PW'(ey_r) * PW'(dx_r);
      l_x_r  <= PW'(dx_r) * PW'(dx_r);
      l_y_r  <= PW'(dy_r) * PW'(dy_r);
      a_x_r  <= PW'(ex_r) * PW'(ex_r);
      a_y_r  <= PW'(ey_r) * PW'(ey_r);
      b_x_r  <= PW'(fx_r) * PW'(fx_r);
      b_y_r  <= PW'(fy_r) * PW'(fy_r);

      t_r   <= SW'(p_tx_r) + SW'(p_ty_r);
      cr_r  <= SW'(p_cx_r) - SW'(p_cy_r);
      len_r <= $unsigned(l_x_r) + $unsigned(l_y_r);
      sqa_r <= $unsigned(a_x_r) + $unsigned(a_y_r);
      sqb_r <= $unsigned(b_x_r) + $unsigned(b_y_r);

      // The foot lies on the segment when 0 <= t <= L; a zero length never does.
      foot4_r  <= (len_r != '0) && !t_r[SW-1] && ($unsigned(t_r[SW-2:0]) <= len_r);
      crmag_r  <= cr_r[SW-1] ? LW'(-cr_r) : LW'(cr_r);
      sqmin4_r <= (sqa_r <= sqb_r) ? sqa_r : sqb_r;
      den4_r   <= ((len_r != '0) && !t_r[SW-1] && ($unsigned(t_r[SW-2:0]) <= len_r))
                  ? len_r : LW'(1);

      hh_r     <= (2 * HW)'(crmag_r[LW-1:HW]) * (2 * HW)'(crmag_r[LW-1:HW]);
      hl_r     <= (2 * HW)'(crmag_r[LW-1:HW]) * (2 * HW)'(crmag_r[HW-1:0]);
      ll_r     <= (2 * HW)'(crmag_r[HW-1:0]) * (2 * HW)'(crmag_r[HW-1:0]);
      foot5_r  <= foot4_r;
      sqmin5_r <= sqmin4_r;
      den5_r   <= den4_r;

      num_r   <= foot5_r ? (crsq << (2 * FRAC_BITS)) : (NW'(sqmin5_r) << (2 * FRAC_BITS));
      foot6_r <= foot5_r;
      den6_r  <= den5_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/psd_queue.sv =====
// Short first-in first-out queue between the front and back pipelines.
`default_nettype none
module psd_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output psd_pkg::psd_q_stat_t  q_stat
);

  logic [WIDTH-1:0]                 mem_r [psd_pkg::QUEUE_DEPTH];
  logic [psd_pkg::QUEUE_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [psd_pkg::QUEUE_CNT_W-1:0]  cnt_r;

  assign q_stat.full  = (cnt_r == psd_pkg::QUEUE_CNT_W'(psd_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == psd_pkg::QUEUE_PTR_W'(psd_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == psd_pkg::QUEUE_PTR_W'(psd_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/psd_back.sv =====
// Back pipeline: restoring divider, digit-by-digit square root and output register.
`default_nettype none
module psd_back #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = psd_pkg::FRAC_BITS_DEF,
  parameter int QDW         = 6 * COORD_WIDTH + 7 + 2 * FRAC_BITS,
  parameter int DIST_WIDTH  = COORD_WIDTH + FRAC_BITS + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire psd_pkg::psd_q_stat_t  q_stat,
  input  wire logic [QDW-1:0]        pop_data,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DIST_WIDTH-1:0]      out_distance,
  output logic                       out_foot_on_segment
);

  localparam int LW = 2 * COORD_WIDTH + 2;
  localparam int NW = 4 * COORD_WIDTH + 4 + 2 * FRAC_BITS;
  localparam int QW = 2 * DIST_WIDTH;
  localparam int RW = DIST_WIDTH + 2;

  logic adv;
  logic [QW-1:0]         dv_r;
  logic [DIST_WIDTH-1:0] sv_r;
  logic [LW-1:0]         rem_r  [QW];
  logic [QW-1:0]         acc_r  [QW];
  logic [LW-1:0]         den_r  [QW];
  logic                  dfoot_r [QW];
  logic [QW-1:0]         rad_r  [DIST_WIDTH];
  logic [RW-1:0]         srem_r [DIST_WIDTH];
  logic [DIST_WIDTH-1:0] root_r [DIST_WIDTH];
  logic                  sfoot_r [DIST_WIDTH];
  logic                  out_valid_r;
  logic [DIST_WIDTH-1:0] dist_r;
  logic                  foot_r;

  logic [NW-1:0] head_num;
  logic [LW-1:0] head_den;
  logic          head_foot;

  assign {head_foot, head_den, head_num} = pop_data;
  assign adv                 = !out_valid_r || out_ready;
  assign pop                 = adv && !q_stat.empty;
  assign out_valid           = out_valid_r;
  assign out_distance        = dist_r;
  assign out_foot_on_segment = foot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r        <= '0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      dv_r        <= {dv_r[QW-2:0], !q_stat.empty};
      sv_r        <= {sv_r[DIST_WIDTH-2:0], dv_r[QW-1]};
      out_valid_r <= sv_r[DIST_WIDTH-1];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [LW-1:0] rem_in;
    logic [QW-1:0] acc_in;
    logic [LW-1:0] den_in;
    logic          foot_in;
    logic [LW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = head_num[NW-1:QW];
      assign acc_in  = head_num[QW-1:0];
      assign den_in  = head_den;
      assign foot_in = head_foot;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign acc_in  = acc_r[k-1];
      assign den_in  = den_r[k-1];
      assign foot_in = dfoot_r[k-1];
    end

    assign trial = {rem_in, acc_in[QW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]   <= ge ? LW'(trial - {1'b0, den_in}) : trial[LW-1:0];
        acc_r[k]   <= {acc_in[QW-2:0], ge};
        den_r[k]   <= den_in;
        dfoot_r[k] <= foot_in;
      end
    end
  end

  for (genvar j = 0; j < DIST_WIDTH; j++) begin : g_sqrt
    logic [QW-1:0]         rad_in;
    logic [RW-1:0]         rem_in;
    logic [DIST_WIDTH-1:0] root_in;
    logic                  foot_in;
    logic [RW-1:0]         cur;
    logic [RW-1:0]         trial;
    logic                  ge;

    if (j == 0) begin : g_first
      assign rad_in  = acc_r[QW-1];
      assign rem_in  = '0;
      assign root_in = '0;
      assign foot_in = dfoot_r[QW-1];
    end else begin : g_next
      assign rad_in  = rad_r[j-1];
      assign rem_in  = srem_r[j-1];
      assign root_in = root_r[j-1];
      assign foot_in = sfoot_r[j-1];
    end

    assign cur   = {rem_in[RW-3:0], rad_in[QW-1:QW-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[j]   <= {rad_in[QW-3:0], 2'b00};
        srem_r[j]  <= ge ? (cur - trial) : cur;
        root_r[j]  <= {root_in[DIST_WIDTH-2:0], ge};
        sfoot_r[j] <= foot_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= root_r[DIST_WIDTH-1];
      foot_r <= sfoot_r[DIST_WIDTH-1];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/psd_checker.sv =====
// Port-level assertions for the point to segment distance block, with its bind.
`default_nettype none
module psd_checker #(
  parameter int DIST_WIDTH = psd_pkg::COORD_WIDTH_DEF + psd_pkg::FRAC_BITS_DEF + 1
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [DIST_WIDTH-1:0] out_distance,
  input wire logic                  out_foot_on_segment
);

  logic       in_beat, out_beat;
  logic [8:0] pend_r;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_beat && !out_beat) begin
      pend_r <= pend_r + 1'b1;
    end else if (!in_beat && out_beat) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_distance) && $stable(out_foot_on_segment))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> pend_r != '0)
    else $error("result beat without a pending input beat");

endmodule

bind point_segment_distance psd_checker #(
  .DIST_WIDTH (COORD_WIDTH + FRAC_BITS + 1)
) u_psd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_distance        (out_ch.distance),
  .out_foot_on_segment (out_ch.foot_on_segment)
);
`default_nettype wire
